### rtl/slc_pkg.sv
// Shared types and constants of the set-associative cache tag and LRU block.
// No dependencies; every other file of the block but the checker refers to this package.
package slc_pkg;

	localparam int ADDR_W     = 32;
	localparam int OFFSET_W   = 5;
	localparam int TAG_W      = ADDR_W - OFFSET_W;
	localparam int LINE_BYTES = 32;
	localparam int WAYS_CNT_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_STORE = 1'b1;

	localparam logic [1:0] PF_NONE   = 2'd0;
	localparam logic [1:0] PF_ALWAYS = 2'd1;
	localparam logic [1:0] PF_MISS   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SET_LOG2  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NO_WALLOC = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PF_MODE   = 2'd3;

	// Classified access as it travels from the front end to the lookup engine.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              alloc;
		logic              pf_always;
		logic              pf_miss;
	} cmd_t;

	// Effective geometry after clamping of the configuration registers.
	typedef struct packed {
		logic [3:0]            set_lg;
		logic [WAYS_CNT_W-1:0] ways;
	} geom_t;

endpackage

### rtl/slc_if.sv
// Channel interfaces of the cache tag block: request, response and configuration.
// Depends on slc_pkg for field widths.
interface slc_req_if;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [slc_pkg::ADDR_W-1:0] address;
	modport source(output valid, operation, address, input ready);
	modport sink(input valid, operation, address, output ready);
endinterface

interface slc_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      demand_hit;
	logic [31:0]               hits_so_far;
	modport source(output valid, demand_hit, hits_so_far, input ready);
	modport sink(input valid, demand_hit, hits_so_far, output ready);
endinterface

interface slc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [slc_pkg::CFG_IDX_W-1:0]  index;
	logic [slc_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/slc_front.sv
// Front end: configuration registers, request acceptance and classification.
// Depends on slc_pkg and the channel interfaces in slc_if.sv.
module slc_front #(
	parameter int MAX_SETS = 512,
	parameter int MAX_WAYS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	slc_req_if.sink         req,
	slc_cfg_if.sink         cfg,
	input  logic            clearing,
	output logic            push_valid,
	input  logic            push_ready,
	output slc_pkg::cmd_t   push_cmd,
	output slc_pkg::geom_t  geom
);

	localparam int SET_LG_MAX = $clog2(MAX_SETS + 1) - 1;

	logic [3:0] set_log2_q;
	logic [4:0] ways_q;
	logic       no_walloc_q;
	logic [1:0] pf_mode_q;
	logic [1:0] mode;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_log2_q  <= 4'd9;
			ways_q      <= 5'd16;
			no_walloc_q <= 1'b0;
			pf_mode_q   <= slc_pkg::PF_NONE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				slc_pkg::REG_SET_LOG2:  set_log2_q  <= cfg.data[3:0];
				slc_pkg::REG_WAYS:      ways_q      <= cfg.data[4:0];
				slc_pkg::REG_NO_WALLOC: no_walloc_q <= cfg.data[0];
				slc_pkg::REG_PF_MODE:   pf_mode_q   <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(set_log2_q) > SET_LG_MAX) geom.set_lg = 4'(SET_LG_MAX);
		else geom.set_lg = set_log2_q;
		if (ways_q == 5'd0) geom.ways = slc_pkg::WAYS_CNT_W'(1);
		else if (32'(ways_q) > MAX_WAYS) geom.ways = slc_pkg::WAYS_CNT_W'(MAX_WAYS);
		else geom.ways = slc_pkg::WAYS_CNT_W'(ways_q);
	end

	// The unused prefetch code behaves as no prefetch.
	assign mode = (pf_mode_q == slc_pkg::PF_ALWAYS || pf_mode_q == slc_pkg::PF_MISS)
		? pf_mode_q : slc_pkg::PF_NONE;

	assign req.ready          = push_ready && !clearing;
	assign push_valid         = req.valid && !clearing;
	assign push_cmd.addr      = req.address;
	assign push_cmd.alloc     = !(mode == slc_pkg::PF_NONE && no_walloc_q
		&& req.operation == slc_pkg::OP_STORE);
	assign push_cmd.pf_always = (mode == slc_pkg::PF_ALWAYS);
	assign push_cmd.pf_miss   = (mode == slc_pkg::PF_MISS);

endmodule

### rtl/slc_queue.sv
// Two-entry queue of classified accesses between front end and lookup engine.
// Depends on slc_pkg for the command type.
module slc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  slc_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output slc_pkg::cmd_t pop_cmd
);

	slc_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

### rtl/slc_back.sv
// Lookup engine: set memory, hit/fill/victim choice, LRU update and hit count.
// Depends on slc_pkg and the response interface in slc_if.sv.
module slc_back #(
	parameter int MAX_SETS = 512,
	parameter int MAX_WAYS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  slc_pkg::geom_t geom,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  slc_pkg::cmd_t  pop_cmd,
	output logic           clearing,
	slc_rsp_if.source      rsp
);

	localparam int TAG_W = slc_pkg::TAG_W;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int LEN_W = $clog2(MAX_WAYS + 1);
	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int ORD_BASE = MAX_WAYS * (1 + TAG_W);
	localparam int ROW_W = MAX_WAYS * (1 + TAG_W + WAY_W) + LEN_W;

	typedef enum logic [1:0] {B_IDLE, B_LOOK, B_PF_RD} bstate_t;

	logic [ROW_W-1:0] mem [MAX_SETS];
	logic [ROW_W-1:0] rdata_s2;

	bstate_t           state_q;
	logic [31:0]       addr_q;
	logic              alloc_q;
	logic              demand_q;
	logic              pf_always_q;
	logic              pf_miss_q;
	logic [31:0]       hits_q;
	logic              out_valid_q;
	logic              out_hit_q;
	logic [31:0]       out_hits_q;
	logic              clr_q;
	logic [SET_W-1:0]  clr_idx_q;

	logic              start;
	logic              re;
	logic [SET_W-1:0]  raddr;
	logic              we;
	logic [SET_W-1:0]  waddr;
	logic [ROW_W-1:0]  wdata;

	logic [MAX_WAYS-1:0] valid_r;
	logic [TAG_W-1:0]    tags_r [MAX_WAYS];
	logic [WAY_W-1:0]    ord_r  [MAX_WAYS];
	logic [LEN_W-1:0]    len_r;
	logic [WAY_W-1:0]    ord_n  [MAX_WAYS];
	logic [LEN_W-1:0]    len_n;
	logic [TAG_W-1:0]    tag;
	logic [SET_W-1:0]    cur_set;
	logic                hit;
	logic [WAY_W-1:0]    hit_way;
	logic                has_inv;
	logic [WAY_W-1:0]    inv_way;
	logic [WAY_W-1:0]    victim;
	logic [WAY_W-1:0]    sel_way;
	logic                found;
	logic [LEN_W-1:0]    pos;
	logic                do_update;
	logic [ROW_W-1:0]    row_n;
	logic                want_pf;

	function automatic logic [SET_W-1:0] set_of(input logic [31:0] a, input logic [3:0] lg);
		logic [31:0] line;
		line = a >> slc_pkg::OFFSET_W;
		return SET_W'(line & ~(32'hFFFF_FFFF << lg));
	endfunction

	assign clearing  = clr_q;
	assign start     = (state_q == B_IDLE) && !clr_q && pop_valid && (!out_valid_q || rsp.ready);
	assign pop_ready = start;

	assign rsp.valid       = out_valid_q;
	assign rsp.demand_hit  = out_hit_q;
	assign rsp.hits_so_far = out_hits_q;

	// Unpack the row read in the previous cycle and work out the lookup.
	always_comb begin
		valid_r = rdata_s2[MAX_WAYS-1:0];
		for (int i = 0; i < MAX_WAYS; i++) begin
			tags_r[i] = rdata_s2[MAX_WAYS + i*TAG_W +: TAG_W];
			ord_r[i]  = rdata_s2[ORD_BASE + i*WAY_W +: WAY_W];
		end
		len_r   = rdata_s2[ROW_W-1 -: LEN_W];
		tag     = TAG_W'(addr_q >> (slc_pkg::OFFSET_W + 32'(geom.set_lg)));
		cur_set = set_of(addr_q, geom.set_lg);

		hit = 1'b0;
		hit_way = '0;
		has_inv = 1'b0;
		inv_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (slc_pkg::WAYS_CNT_W'(i) < geom.ways) begin
				if (valid_r[i] && tags_r[i] == tag) begin
					hit = 1'b1;
					hit_way = WAY_W'(i);
				end
				if (!valid_r[i]) begin
					has_inv = 1'b1;
					inv_way = WAY_W'(i);
				end
			end
		end

		// Victim: least recent entry of the order that names a way in use.
		victim = '0;
		for (int k = 0; k < MAX_WAYS; k++) begin
			if (LEN_W'(k) < len_r && slc_pkg::WAYS_CNT_W'(ord_r[k]) < geom.ways)
				victim = ord_r[k];
		end

		if (hit) sel_way = hit_way;
		else if (has_inv) sel_way = inv_way;
		else sel_way = victim;
		do_update = hit || alloc_q;

		// Move the chosen way to the front of the order.
		found = 1'b0;
		pos = len_r;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (LEN_W'(i) < len_r && ord_r[i] == sel_way) begin
				found = 1'b1;
				pos = LEN_W'(i);
			end
		end
		len_n = len_r;
		if (!found) begin
			if (len_r < LEN_W'(MAX_WAYS)) len_n = len_r + LEN_W'(1);
			else pos = LEN_W'(MAX_WAYS - 1);
		end
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (i == 0) ord_n[i] = sel_way;
			else if (LEN_W'(i) <= pos) ord_n[i] = ord_r[i-1];
			else ord_n[i] = ord_r[i];
		end

		row_n = rdata_s2;
		if (!hit) begin
			row_n[sel_way] = 1'b1;
			row_n[MAX_WAYS + 32'(sel_way)*TAG_W +: TAG_W] = tag;
		end
		for (int i = 0; i < MAX_WAYS; i++)
			row_n[ORD_BASE + i*WAY_W +: WAY_W] = ord_n[i];
		row_n[ROW_W-1 -: LEN_W] = len_n;

		want_pf = demand_q && (pf_always_q || (pf_miss_q && !hit));
	end

	always_comb begin
		re = 1'b0;
		raddr = set_of(pop_cmd.addr, geom.set_lg);
		if (start) re = 1'b1;
		else if (state_q == B_PF_RD) begin
			re = 1'b1;
			raddr = cur_set;
		end
		we = 1'b0;
		waddr = cur_set;
		wdata = row_n;
		if (clr_q) begin
			we = 1'b1;
			waddr = clr_idx_q;
			wdata = '0;
		end else if (state_q == B_LOOK && do_update) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_s2 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			addr_q      <= '0;
			alloc_q     <= 1'b0;
			demand_q    <= 1'b0;
			pf_always_q <= 1'b0;
			pf_miss_q   <= 1'b0;
			hits_q      <= '0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_hits_q  <= '0;
			clr_q       <= 1'b1;
			clr_idx_q   <= '0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + SET_W'(1);
				if (clr_idx_q == SET_W'(MAX_SETS - 1)) clr_q <= 1'b0;
			end
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (start) begin
						addr_q      <= pop_cmd.addr;
						alloc_q     <= pop_cmd.alloc;
						pf_always_q <= pop_cmd.pf_always;
						pf_miss_q   <= pop_cmd.pf_miss;
						demand_q    <= 1'b1;
						state_q     <= B_LOOK;
					end
				end
				B_LOOK: begin
					if (demand_q) begin
						hits_q      <= hits_q + 32'(hit);
						out_valid_q <= 1'b1;
						out_hit_q   <= hit;
						out_hits_q  <= hits_q + 32'(hit);
					end
					if (want_pf) begin
						addr_q   <= addr_q + 32'(slc_pkg::LINE_BYTES);
						alloc_q  <= 1'b1;
						demand_q <= 1'b0;
						state_q  <= B_PF_RD;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_PF_RD: state_q <= B_LOOK;
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

### rtl/set_assoc_lru_cache_tags_top.sv
// Top level of the set-associative cache tag, valid and LRU block.
// Depends on slc_pkg, slc_if, slc_front, slc_queue and slc_back.
//
//  channel  | modport | payload                    | role
//  ---------+---------+----------------------------+------------------------------
//  req      | sink    | operation, address         | one load or store access
//  rsp      | source  | demand_hit, hits_so_far    | one result per access
//  cfg      | sink    | index, data                | register writes, always ready
//
// A demand lookup first reads the set's row into a register, then does the tag
// compare, way choice and row write-back. A next-line prefetch adds a second row
// read and lookup, for the next line.
// After reset a clearing pass writes all MAX_SETS rows, one per cycle, and no request
// is taken until it ends; configuration writes are taken throughout. Up to two
// accesses wait in the queue; a lookup starts only when the result register is free.
module set_assoc_lru_cache_tags_top #(
	parameter int MAX_SETS = 512,
	parameter int MAX_WAYS = 16
) (
	input  logic clk,
	input  logic arst_n,
	slc_req_if.sink   req,
	slc_rsp_if.source rsp,
	slc_cfg_if.sink   cfg
);

	// Front end to queue.
	logic          push_valid;
	logic          push_ready;
	slc_pkg::cmd_t push_cmd;
	// Queue to lookup engine.
	logic          pop_valid;
	logic          pop_ready;
	slc_pkg::cmd_t pop_cmd;
	// Clamped geometry; the user must keep it stable while the block is busy, the block does not enforce this.
	slc_pkg::geom_t geom;
	// High during the post-reset clearing pass.
	logic          clearing;

	slc_front #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.geom       (geom)
	);

	slc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	slc_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.clearing  (clearing),
		.rsp       (rsp)
	);

endmodule

### rtl/slc_checker.sv
// Port-level checks for the cache tag block, bound to its top level.
// Depends only on the top level's ports.
module slc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_hit,
	input logic [31:0] out_hits,
	input logic        cfg_ready
);

	logic [31:0] last_hits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_hits_q <= '0;
		else if (out_valid && out_ready) last_hits_q <= out_hits;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hits) && $stable(out_hit))
		else $error("response changed while stalled");

	a_count_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_hit |-> out_hits == last_hits_q + 32'd1)
		else $error("hit count did not advance on a hit");

	a_count_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_hit |-> out_hits == last_hits_q)
		else $error("hit count changed on a miss");

	a_clear: assert property (@(posedge clk) $rose(arst_n) |-> !in_ready)
		else $error("request taken before the clearing pass");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind set_assoc_lru_cache_tags_top slc_checker u_slc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_hit   (rsp.demand_hit),
	.out_hits  (rsp.hits_so_far),
	.cfg_ready (cfg.ready)
);
